@@ hw/rtl/jiq_pkg.sv @@
// Shared types and constants for the jump integral quadrature unit.
`default_nettype none
package jiq_pkg;

  localparam int JIQ_GRID_POINTS = 64;
  localparam int JIQ_QUAD_NODES  = 20;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_JUMP_INTENSITY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_MULT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NODE_RATIO     = 2'd2;

  localparam logic [23:0] RST_JUMP_INTENSITY = 24'd0;
  localparam logic [31:0] RST_FIRST_MULT     = 32'd16777216;
  localparam logic [31:0] RST_NODE_RATIO     = 32'd1073741824;

  localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444048;
  localparam int          DIV_STEPS        = 30;

  typedef struct packed {
    logic load;
    logic rd_zero;
    logic rd_last;
    logic cap_lo;
    logic rd_point;
    logic cap_point;
    logic mul;
    logic chk;
    logic scan_rd;
    logic scan_cmp;
    logic vrd;
    logic seg;
    logic div;
    logic intp;
    logic intv;
    logic term;
    logic acc;
    logic fin1;
    logic fin2;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic ends_direct;
    logic scan_more;
    logic seg_direct;
    logic div_done;
    logic node_last;
    logic point_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/jiq_ctrl.sv @@
// Sequencer for loading, node quadrature and result issue.
`default_nettype none
module jiq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jiq_pkg::status_t sts,
  output jiq_pkg::cmd_t        cmd
);
  import jiq_pkg::*;

  typedef enum logic [18:0] {
    S_LOAD = 19'h00001,
    S_RD0  = 19'h00002,
    S_RDN  = 19'h00004,
    S_RDL  = 19'h00008,
    S_RDI  = 19'h00010,
    S_PT   = 19'h00020,
    S_MUL  = 19'h00040,
    S_CHK  = 19'h00080,
    S_SRD  = 19'h00100,
    S_SCMP = 19'h00200,
    S_VRD  = 19'h00400,
    S_SEG  = 19'h00800,
    S_DIV  = 19'h01000,
    S_INTP = 19'h02000,
    S_INTV = 19'h04000,
    S_TERM = 19'h08000,
    S_ACC  = 19'h10000,
    S_FIN1 = 19'h20000,
    S_FIN2 = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (sts.last_in) state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RDN;
      S_RDN:  state_nxt = S_RDL;
      S_RDL:  state_nxt = S_RDI;
      S_RDI:  state_nxt = S_PT;
      S_PT:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = sts.ends_direct ? S_TERM : S_SRD;
      S_SRD:  state_nxt = S_SCMP;
      S_SCMP: state_nxt = sts.scan_more ? S_SRD : S_VRD;
      S_VRD:  state_nxt = S_SEG;
      S_SEG:  state_nxt = sts.seg_direct ? S_TERM : S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_INTP;
      S_INTP: state_nxt = S_INTV;
      S_INTV: state_nxt = S_TERM;
      S_TERM: state_nxt = S_ACC;
      S_ACC:  state_nxt = sts.node_last ? S_FIN1 : S_MUL;
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: begin
        if (!sts.out_busy) state_nxt = sts.point_last ? S_LOAD : S_RDI;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_LOAD);
    cmd.rd_zero   = (state_r == S_RD0);
    cmd.rd_last   = (state_r == S_RDN);
    cmd.cap_lo    = (state_r == S_RDN);
    cmd.rd_point  = (state_r == S_RDI);
    cmd.cap_point = (state_r == S_PT);
    cmd.mul       = (state_r == S_MUL);
    cmd.chk       = (state_r == S_CHK);
    cmd.scan_rd   = (state_r == S_SRD);
    cmd.scan_cmp  = (state_r == S_SCMP);
    cmd.vrd       = (state_r == S_VRD);
    cmd.seg       = (state_r == S_SEG);
    cmd.div       = (state_r == S_DIV);
    cmd.intp      = (state_r == S_INTP);
    cmd.intv      = (state_r == S_INTV);
    cmd.term      = (state_r == S_TERM);
    cmd.acc       = (state_r == S_ACC);
    cmd.fin1      = (state_r == S_FIN1);
    cmd.fin2      = (state_r == S_FIN2) && !sts.out_busy;
  end

endmodule
`default_nettype wire

@@ hw/rtl/jiq_dp.sv @@
// Datapath: grid stores, node multiplier, search, divider and accumulator.
`default_nettype none
module jiq_dp #(
  parameter int GRID_POINTS = jiq_pkg::JIQ_GRID_POINTS,
  parameter int QUAD_NODES  = jiq_pkg::JIQ_QUAD_NODES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire jiq_pkg::cmd_t               cmd,
  output jiq_pkg::status_t                 sts,
  input  wire logic                        cfg_we,
  input  wire logic [jiq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [jiq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  input  wire logic [31:0]                 in_price,
  input  wire logic [31:0]                 in_value,
  input  wire logic                        in_last,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [31:0]                      out_value,
  output logic [$clog2(GRID_POINTS)-1:0]   out_index,
  output logic                             out_sat,
  output logic                             out_last
);
  import jiq_pkg::*;

  localparam int AW = $clog2(GRID_POINTS);
  localparam int CW = $clog2(GRID_POINTS + 1);
  localparam int JW = $clog2(QUAD_NODES);

  function automatic logic [63:0] node_weight(input int j);
    int          d;
    logic [63:0] ad;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] t;
    d  = 8 * j + 4 - 4 * QUAD_NODES;
    ad = 64'(d < 0 ? -d : d);
    x  = ((ad * ad) << 32) / 64'(2 * QUAD_NODES * QUAD_NODES);
    y  = x >> 4;
    e  = 64'h1_0000_0000;
    t  = 64'h1_0000_0000;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * y) >> 32) / 64'(k);
      if (k % 2 == 1) e = e - t;
      else e = e + t;
    end
    for (int k = 0; k < 4; k++) begin
      if (e < 64'h1_0000_0000) e = (e * e) >> 32;
    end
    return ((e * INV_SQRT_2PI_Q32) >> 32) * 64'd8 / 64'(QUAD_NODES);
  endfunction

  logic [31:0] weight_tab [QUAD_NODES];
  for (genvar g = 0; g < QUAD_NODES; g++) begin : g_weight
    assign weight_tab[g] = 32'(node_weight(g));
  end

  // configuration
  logic [23:0] lambda_r;
  logic [31:0] first_mult_r, ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r     <= RST_JUMP_INTENSITY;
      first_mult_r <= RST_FIRST_MULT;
      ratio_r      <= RST_NODE_RATIO;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_JUMP_INTENSITY) lambda_r <= cfg_data[23:0];
      if (cfg_addr == CFG_FIRST_MULT) first_mult_r <= cfg_data;
      if (cfg_addr == CFG_NODE_RATIO) ratio_r <= cfg_data;
    end
  end

  // grid stores
  logic [31:0] price_mem [GRID_POINTS];
  logic [31:0] value_mem [GRID_POINTS];
  logic [31:0] price_rd_r, value_rd_r;
  logic [AW-1:0] price_addr, value_addr;

  logic [CW-1:0] count_r, n_r;
  logic [AW-1:0] i_r, k_r;
  logic [JW-1:0] j_r;
  logic          wr_en;

  assign wr_en = cmd.load && in_valid && (count_r < CW'(GRID_POINTS));

  always_comb begin
    priority if (cmd.rd_zero) begin
      price_addr = '0;
      value_addr = '0;
    end else if (cmd.rd_last) begin
      price_addr = AW'(n_r - 1'b1);
      value_addr = AW'(n_r - 1'b1);
    end else if (cmd.rd_point) begin
      price_addr = i_r;
      value_addr = i_r;
    end else if (cmd.scan_rd) begin
      price_addr = AW'(k_r + 1'b1);
      value_addr = k_r;
    end else begin
      price_addr = AW'(k_r + 1'b1);
      value_addr = AW'(k_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      price_mem[count_r[AW-1:0]] <= in_price;
      value_mem[count_r[AW-1:0]] <= in_value;
    end
    price_rd_r <= price_mem[price_addr];
    value_rd_r <= value_mem[value_addr];
  end

  // working registers
  logic [31:0]        lo_r, hi_r, p0_r, p1_r, pi_r, mult_r;
  logic signed [31:0] v0_r, vlast_r, vi_r, vk_r, v_r;
  logic [63:0]        p_r;
  logic [57:0]        rem_r;
  logic [29:0]        alpha_r;
  logic [4:0]         dcnt_r;
  logic signed [63:0] prodi_r;
  logic signed [64:0] prodw_r;
  logic signed [47:0] sum_r;
  logic signed [56:0] prodc_r;

  logic [63:0] lo_s, hi_s, p0_s, p1_s, pd_s;
  assign lo_s = {8'd0, lo_r, 24'd0};
  assign hi_s = {8'd0, hi_r, 24'd0};
  assign p0_s = {8'd0, p0_r, 24'd0};
  assign p1_s = {8'd0, p1_r, 24'd0};
  assign pd_s = {8'd0, price_rd_r, 24'd0};

  logic p_le_lo, p_ge_hi, seg_k, seg_k1;
  assign p_le_lo = (p_r <= lo_s);
  assign p_ge_hi = (p_r >= hi_s);
  assign seg_k   = (p1_s <= p0_s) || (p_r <= p0_s);
  assign seg_k1  = (p_r >= p1_s);

  logic [57:0] rem_sh;
  logic [57:0] den;
  assign rem_sh = {rem_r[56:0], 1'b0};
  assign den    = {2'b0, p1_s[55:0] - p0_s[55:0]};

  logic [63:0] mult_prod;
  logic [33:0] mult_q;
  assign mult_prod = 64'(mult_r) * 64'(ratio_r);
  assign mult_q    = mult_prod[63:30];

  logic signed [63:0] prodi_adj;
  logic signed [31:0] v_interp;
  assign prodi_adj = prodi_r + (prodi_r < 0 ? 64'sd1073741823 : 64'sd0);
  assign v_interp  = 32'(vk_r + 32'(prodi_adj >>> 30));

  logic signed [64:0] prodw_adj;
  logic signed [49:0] term_ext, sum_new;
  assign prodw_adj = prodw_r + (prodw_r < 0 ? 65'sd65535 : 65'sd0);
  assign term_ext  = 50'(prodw_adj >>> 16);
  assign sum_new   = 50'(sum_r) + term_ext;

  localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SUM_MIN = -50'sh0_8000_0000_0000;

  logic signed [47:0] sum_adj;
  logic signed [31:0] s16;
  assign sum_adj = sum_r + (sum_r < 0 ? 48'sd65535 : 48'sd0);
  assign s16     = 32'(sum_adj >>> 16);

  logic signed [56:0] prodc_adj;
  logic signed [41:0] nv;
  assign prodc_adj = prodc_r + (prodc_r < 0 ? 57'sd65535 : 57'sd0);
  assign nv        = 42'(vi_r) + 42'(prodc_adj >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      lo_r <= price_rd_r;
      v0_r <= value_rd_r;
    end
    if (cmd.cap_point) begin
      pi_r   <= price_rd_r;
      vi_r   <= value_rd_r;
      mult_r <= first_mult_r;
      sum_r  <= '0;
    end
    if (cmd.mul) p_r <= 64'(pi_r) * 64'(mult_r);
    if (cmd.chk) begin
      if (p_le_lo) v_r <= v0_r;
      else if (p_ge_hi) v_r <= vlast_r;
      p0_r <= lo_r;
    end
    if (cmd.scan_cmp) begin
      if (pd_s < p_r) begin
        p0_r <= price_rd_r;
      end else begin
        p1_r <= price_rd_r;
        vk_r <= value_rd_r;
      end
    end
    if (cmd.seg) begin
      if (seg_k) v_r <= vk_r;
      else if (seg_k1) v_r <= value_rd_r;
      rem_r   <= {2'b0, p_r[55:0] - p0_s[55:0]};
      alpha_r <= '0;
      dcnt_r  <= '0;
      prodi_r <= 64'($signed(value_rd_r)) - 64'(vk_r);
    end
    if (cmd.div) begin
      if (rem_sh >= den) begin
        rem_r   <= rem_sh - den;
        alpha_r <= {alpha_r[28:0], 1'b1};
      end else begin
        rem_r   <= rem_sh;
        alpha_r <= {alpha_r[28:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.intp) prodi_r <= prodi_r * $signed({34'd0, alpha_r});
    if (cmd.intv) v_r <= v_interp;
    if (cmd.term) begin
      prodw_r <= 65'(v_r) * $signed({33'd0, weight_tab[j_r]});
      mult_r  <= (mult_q[33:32] != 2'b00) ? 32'hFFFF_FFFF : mult_q[31:0];
    end
    if (cmd.acc) begin
      if (sum_new > SUM_MAX) sum_r <= SUM_MAX[47:0];
      else if (sum_new < SUM_MIN) sum_r <= SUM_MIN[47:0];
      else sum_r <= sum_new[47:0];
    end
    if (cmd.fin1) prodc_r <= 57'(s16) * $signed({33'd0, lambda_r});
  end

  // hi end captured the cycle after the last-entry read
  logic rd_last_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_last_d_r <= 1'b0;
    end else begin
      rd_last_d_r <= cmd.rd_last;
    end
    if (rd_last_d_r) begin
      hi_r    <= price_rd_r;
      vlast_r <= value_rd_r;
    end
  end

  // counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      n_r       <= '0;
      i_r       <= '0;
      k_r       <= '0;
      j_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) count_r <= count_r + 1'b1;
      if (cmd.load && in_valid && in_last) begin
        n_r <= wr_en ? count_r + 1'b1 : count_r;
        i_r <= '0;
      end
      if (cmd.cap_point) j_r <= '0;
      if (cmd.chk) k_r <= '0;
      if (cmd.scan_cmp && (pd_s < p_r)) k_r <= AW'(k_r + 1'b1);
      if (cmd.acc) j_r <= JW'(j_r + 1'b1);
      if (cmd.fin2) begin
        out_valid <= 1'b1;
        if (sts.point_last) count_r <= '0;
        else i_r <= AW'(i_r + 1'b1);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin2) begin
      out_index <= i_r;
      out_last  <= sts.point_last;
      if (nv > 42'sd2147483647) begin
        out_value <= 32'h7FFF_FFFF;
        out_sat   <= 1'b1;
      end else if (nv < -42'sd2147483648) begin
        out_value <= 32'h8000_0000;
        out_sat   <= 1'b1;
      end else begin
        out_value <= nv[31:0];
        out_sat   <= 1'b0;
      end
    end
  end

  always_comb begin
    sts             = '0;
    sts.last_in     = in_valid && in_last;
    sts.ends_direct = p_le_lo || p_ge_hi;
    sts.scan_more   = (pd_s < p_r);
    sts.seg_direct  = seg_k || seg_k1;
    sts.div_done    = (dcnt_r == 5'(DIV_STEPS - 1));
    sts.node_last   = (j_r == JW'(QUAD_NODES - 1));
    sts.point_last  = ((CW'(i_r) + 1'b1) == n_r);
    sts.out_busy    = out_valid && !out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(GRID_POINTS))
    else $error("point count beyond grid size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> ((CW'(k_r) + 1'b1) < n_r))
    else $error("segment search past last loaded point");

  a_index_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin2 |-> (CW'(i_r) < n_r))
    else $error("result index outside loaded batch");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (dcnt_r < 5'(DIV_STEPS)))
    else $error("divider ran past its step count");

endmodule
`default_nettype wire

@@ hw/rtl/jump_integral_quadrature_unit.sv @@
// Top level of the jump integral quadrature unit.
//
// Load grid points on the in_ stream, one word per point, in ascending price
// order; tlast marks the final point and starts the computation. Points past
// GRID_POINTS are dropped. While computing, in_tready is low.
// One result word per loaded point then leaves on the out_ stream in index
// order, tlast set on the final one, tuser set when the value was clamped.
// Per point the sequencer reads the point, then for each of the QUAD_NODES
// nodes scales its price and skips the search when the jumped price lies
// outside the grid; else it runs a linear search for the segment k (one store
// read per step) and, unless the price meets a segment end, the bit-serial
// divider, so nodes outside the grid finish sooner. A batch first reads both
// grid ends. A result waits in the output register; when the receiver
// stalls, the unit holds before issuing the next result. Configuration
// writes on cfg_ are to be taken only while idle; the unit itself does not
// enforce this. Reset clears the configuration to its defaults, the point
// count and the sequencer; store contents stay undefined until written.
`default_nettype none
module jump_integral_quadrature_unit #(
  parameter int GRID_POINTS = jiq_pkg::JIQ_GRID_POINTS,
  parameter int QUAD_NODES  = jiq_pkg::JIQ_QUAD_NODES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [jiq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [jiq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [63:0]                    in_tdata,  // grid_price, grid_value
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [39:0]                         out_tdata, // new_value, point_index
  output logic                                out_tuser, // saturated
  output logic                                out_tlast
);
  import jiq_pkg::*;

  localparam int AW = $clog2(GRID_POINTS);

  cmd_t          cmd;
  status_t       sts;
  logic [31:0]   new_value;
  logic [AW-1:0] idx;

  jiq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  jiq_dp #(
    .GRID_POINTS (GRID_POINTS),
    .QUAD_NODES  (QUAD_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_price  (in_tdata[31:0]),
    .in_value  (in_tdata[63:32]),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_value (new_value),
    .out_index (idx),
    .out_sat   (out_tuser),
    .out_last  (out_tlast)
  );

  assign in_tready = cmd.load;
  assign out_tdata = {2'b00, 6'(idx), new_value};

endmodule
`default_nettype wire

@@ verif/tb_jump_integral_quadrature_unit.sv @@
// Testbench for the jump integral quadrature unit: stream stimulus, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none

class jiq_scoreboard;
  logic [23:0] intensity;
  logic [31:0] first_mult;
  logic [31:0] ratio;
  logic [31:0] prices[64];
  logic signed [31:0] values[64];
  int unsigned count;
  logic [39:0] pending_data[$];
  logic pending_sat[$];
  logic pending_last[$];
  int errors;

  function new();
    intensity = jiq_pkg::RST_JUMP_INTENSITY;
    first_mult = jiq_pkg::RST_FIRST_MULT;
    ratio = jiq_pkg::RST_NODE_RATIO;
    count = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] addr, logic [31:0] data);
    case (addr)
      jiq_pkg::CFG_JUMP_INTENSITY: intensity = data[23:0];
      jiq_pkg::CFG_FIRST_MULT: first_mult = data;
      jiq_pkg::CFG_NODE_RATIO: ratio = data;
      default: ;
    endcase
  endfunction

  function automatic longint unsigned weight(int j);
    longint d;
    longint unsigned ad, x, y, e, t;
    d = 8 * j + 4 - 4 * 20;
    ad = (d < 0) ? -d : d;
    x = ((ad * ad) << 32) / 800;
    y = x >> 4;
    e = 64'h1_0000_0000;
    t = e;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * y) >> 32) / k;
      if (k % 2 == 1) e = e - t;
      else e = e + t;
    end
    for (int k = 0; k < 4; k++) if (e < 64'h1_0000_0000) e = (e * e) >> 32;
    return ((e * 64'd1713444048) >> 32) * 8 / 20;
  endfunction

  function automatic longint interp(longint unsigned p, int n);
    longint unsigned p0, p1, num, den, r, alpha;
    int k;
    longint dv;
    if (p <= (longint'(prices[0]) << 24)) return values[0];
    if (p >= (longint'(prices[n-1]) << 24)) return values[n-1];
    k = 0;
    while (k + 1 < n && (longint'(prices[k+1]) << 24) < p) k++;
    if (k + 1 >= n) return values[n-1];
    p0 = longint'(prices[k]) << 24;
    p1 = longint'(prices[k+1]) << 24;
    if (p1 <= p0 || p <= p0) return values[k];
    if (p >= p1) return values[k+1];
    num = p - p0;
    den = p1 - p0;
    r = num;
    alpha = 0;
    for (int b = 0; b < 30; b++) begin
      r = r << 1;
      alpha = alpha << 1;
      if (r >= den) begin
        r = r - den;
        alpha = alpha | 1;
      end
    end
    dv = longint'(values[k+1]) - longint'(values[k]);
    return longint'(values[k]) + (dv * longint'(alpha)) / (64'sd1 << 30);
  endfunction

  function void note_input(logic [31:0] price, logic [31:0] value, logic last);
    longint sum, term, s16, contrib, nv;
    longint unsigned mult, nm;
    logic sat;
    if (count < 64) begin
      prices[count] = price;
      values[count] = value;
      count++;
    end
    if (!last) return;
    for (int i = 0; i < count; i++) begin
      mult = first_mult;
      sum = 0;
      sat = 0;
      for (int j = 0; j < 20; j++) begin
        term = (interp(longint'(prices[i]) * mult, count) * longint'(weight(j))) / 65536;
        nm = (mult * longint'(ratio)) >> 30;
        sum = sum + term;
        if (sum > 64'sd140737488355327) sum = 64'sd140737488355327;
        if (sum < -64'sd140737488355328) sum = -64'sd140737488355328;
        mult = (nm > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nm;
      end
      s16 = sum / 65536;
      contrib = (s16 * longint'(intensity)) / 65536;
      nv = longint'(values[i]) + contrib;
      if (nv > 64'sd2147483647) begin
        nv = 64'sd2147483647;
        sat = 1;
      end
      if (nv < -64'sd2147483648) begin
        nv = -64'sd2147483648;
        sat = 1;
      end
      pending_data.push_back({2'b00, 6'(i), nv[31:0]});
      pending_sat.push_back(sat);
      pending_last.push_back(i + 1 == count);
    end
    count = 0;
  endfunction

  function void report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endfunction

  function void check_result(logic [39:0] data, logic sat, logic last);
    logic [39:0] d;
    logic s, l;
    if (pending_data.size() == 0) begin
      report("unexpected word", data, '0);
      return;
    end
    d = pending_data.pop_front();
    s = pending_sat.pop_front();
    l = pending_last.pop_front();
    if (data[31:0] !== d[31:0]) report("new_value", data, d);
    if (data[37:32] !== d[37:32]) report("point_index", data, d);
    if (sat !== s) report("saturated", 40'(sat), 40'(s));
    if (last !== l) report("last_result", 40'(last), 40'(l));
  endfunction
endclass

module tb_jump_integral_quadrature_unit;
  import jiq_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_tvalid, in_tready, in_tlast;
  logic [63:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [39:0] out_tdata;
  int idle_cycles = 0;
  jiq_scoreboard sb;

  jump_integral_quadrature_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver with random stalls
  initial begin
    int gap;
    out_tready = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 8);
      repeat (gap) @(negedge clk);
      out_tready = 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser, out_tlast);
      @(negedge clk);
      out_tready = 0;
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] price, logic [31:0] value, logic last);
    int gap;
    gap = $urandom_range(0, 8);
    repeat (gap) @(negedge clk);
    in_tdata = {value, price};
    in_tlast = last;
    in_tvalid = 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(price, value, last);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_addr = addr;
    cfg_data = data;
    sb.set_reg(addr, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (sb.pending_data.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // well-formed ascending grid of n points with random spacing
  task automatic send_grid(int n, int spacing_max);
    logic [31:0] p;
    p = $urandom_range(0, 32'h0004_0000);
    for (int i = 0; i < n; i++) begin
      send_point(p, $urandom, i == n - 1);
      p = p + $urandom_range(1, spacing_max);
    end
  endtask

  initial begin
    int n;
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // no jumps: values pass through, extremes of fields
    send_point(32'h0, 32'h8000_0000, 0);
    send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
    drain();
    // single point
    write_reg(CFG_JUMP_INTENSITY, 32'hFF_FFFF);
    send_point(32'h0001_0000, 32'h7FFF_FFFF, 1);
    drain();
    // zero spread, unsorted prices
    write_reg(CFG_FIRST_MULT, 32'h0100_0000);
    write_reg(CFG_NODE_RATIO, 32'h4000_0000);
    send_point(32'h0003_0000, 32'h0001_0000, 0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 0);
    send_point(32'h0001_0000, 32'h0005_0000, 0);
    send_point(32'h0004_0000, 32'h8000_0000, 1);
    drain();
    // spread grid, moderate lambda
    write_reg(CFG_JUMP_INTENSITY, 32'h0_8000);
    write_reg(CFG_FIRST_MULT, 32'h00C0_0000);
    write_reg(CFG_NODE_RATIO, 32'h4400_0000);
    send_grid(6, 32'h0000_8000);
    drain();
    // extreme registers
    write_reg(CFG_FIRST_MULT, 32'hFFFF_FFFF);
    write_reg(CFG_NODE_RATIO, 32'hFFFF_FFFF);
    send_grid(3, 32'h0100_0000);
    drain();
    write_reg(CFG_FIRST_MULT, 32'h0);
    send_grid(3, 32'h0001_0000);
    drain();
    // too many points: 66 sent, last mark on a dropped one
    write_reg(CFG_JUMP_INTENSITY, 32'h1_0000);
    write_reg(CFG_FIRST_MULT, 32'h0080_0000);
    write_reg(CFG_NODE_RATIO, 32'h4200_0000);
    send_grid(66, 32'h0000_4000);
    drain();

    // random batches, mostly small
    for (int b = 0; b < 48; b++) begin
      if (b % 8 == 0) begin
        drain();
        write_reg(CFG_JUMP_INTENSITY, $urandom);
        write_reg(CFG_FIRST_MULT, $urandom_range(32'h0060_0000, 32'h0100_0000));
        write_reg(CFG_NODE_RATIO, $urandom_range(32'h4000_0000, 32'h4800_0000));
      end
      n = (b % 13 == 12) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < n; i++) send_point($urandom, $urandom, i == n - 1);
      end else begin
        send_grid(n, $urandom_range(16, 32'h0004_0000));
      end
      if (b % 4 == 0) drain();
    end
    drain();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
